@@ src/cbc_pkg.sv @@
// Package for the cartridge bank controller: transaction payload types,
// access kind and error codes, bus address map and register indexes.
// No dependencies.
package cbc_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  access_kind;
        logic [2:0]  error_code;
        logic [20:0] physical_address;
        logic [7:0]  ram_write_byte;
    } t_out_item;

    // access kinds
    localparam logic [2:0] KIND_ROM_READ  = 3'd0;
    localparam logic [2:0] KIND_RAM_READ  = 3'd1;
    localparam logic [2:0] KIND_RAM_WRITE = 3'd2;
    localparam logic [2:0] KIND_CONTROL   = 3'd3;
    localparam logic [2:0] KIND_IGNORED   = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_RAM_OFF   = 3'd1;
    localparam logic [2:0] ERR_RAM_RANGE = 3'd2;
    localparam logic [2:0] ERR_UNMAPPED  = 3'd3;
    localparam logic [2:0] ERR_ROM_RANGE = 3'd4;

    // bus map: bits [15:13] of the address select an 8 KiB region
    localparam logic [2:0] REGION_RAM_WINDOW = 3'b101;  // 0xA000-0xBFFF
    // bits [14:13] of a control write below 0x8000
    localparam logic [1:0] CTRL_RAM_ENABLE = 2'd0;      // 0x0000-0x1FFF
    localparam logic [1:0] CTRL_LOW_BANK   = 2'd1;      // 0x2000-0x3FFF
    localparam logic [1:0] CTRL_UPPER_BITS = 2'd2;      // 0x4000-0x5FFF
    localparam logic [1:0] CTRL_BANK_MODE  = 2'd3;      // 0x6000-0x7FFF

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    // configuration register indexes
    localparam logic [1:0] REG_CONTROLLER_KIND = 2'd0;
    localparam logic [1:0] REG_RAM_BYTES       = 2'd1;
    localparam logic [1:0] REG_RAM_IS_BANKED   = 2'd2;
    localparam logic [1:0] REG_ROM_BYTES       = 2'd3;

    localparam logic [22:0] ROM_BYTES_RESET = 23'd32768;

endpackage

@@ src/cartridge_bank_controller.sv @@
// A result is registered and appears in the cycle after its transaction is accepted.
// One transaction per cycle while the output is not stalled; the decode, bank select and size
// compares sit between the input handshake and the result register.
// Reset (synchronous, active low): MBC1 mode, no RAM, 32 KiB ROM, RAM
// disabled, low bank 1, upper bits 0, ROM banking mode, output empty.
// Top level of the cartridge bank controller; uses cbc_pkg.
module cartridge_bank_controller
    import cbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    logic        r_controller_kind;
    logic [15:0] r_ram_bytes;
    logic        r_ram_is_banked;
    logic [22:0] r_rom_bytes;

    // bank state
    logic        r_ram_enable, n_ram_enable;
    logic [4:0]  r_low_bank, n_low_bank;
    logic [1:0]  r_upper_bits, n_upper_bits;
    logic        r_banking_mode, n_banking_mode;

    logic        r_out_valid;
    t_out_item   r_out_data, n_out_data;

    logic        in_fire;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] addr;
    logic [12:0] ram_off;
    logic [6:0]  rom_bank;
    logic [4:0]  low_bank_wr;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_comb begin
        unique case (cfg_index)
            REG_CONTROLLER_KIND: prdata = {31'd0, r_controller_kind};
            REG_RAM_BYTES:       prdata = {16'd0, r_ram_bytes};
            REG_RAM_IS_BANKED:   prdata = {31'd0, r_ram_is_banked};
            REG_ROM_BYTES:       prdata = {9'd0, r_rom_bytes};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_controller_kind <= 1'b1;
            r_ram_bytes       <= 16'd0;
            r_ram_is_banked   <= 1'b0;
            r_rom_bytes       <= ROM_BYTES_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_CONTROLLER_KIND: r_controller_kind <= pwdata[0];
                REG_RAM_BYTES:       r_ram_bytes       <= pwdata[15:0];
                REG_RAM_IS_BANKED:   r_ram_is_banked   <= pwdata[0];
                REG_ROM_BYTES:       r_rom_bytes       <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    // hold input while a finished result waits downstream
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign addr        = i_in_data.bus_address;
    assign ram_off     = addr[12:0];
    assign rom_bank    = r_banking_mode ? {2'b00, r_low_bank} : {r_upper_bits, r_low_bank};
    assign low_bank_wr = i_in_data.write_byte[4:0];

    always_comb begin
        n_out_data     = '0;
        n_ram_enable   = r_ram_enable;
        n_low_bank     = r_low_bank;
        n_upper_bits   = r_upper_bits;
        n_banking_mode = r_banking_mode;

        if (!r_controller_kind) begin
            if (i_in_data.mode) begin
                n_out_data.access_kind = KIND_IGNORED;
            end else begin
                n_out_data.access_kind = KIND_ROM_READ;
                if ({7'd0, addr} >= r_rom_bytes) begin
                    n_out_data.error_code = ERR_ROM_RANGE;
                end else begin
                    n_out_data.physical_address = {5'd0, addr};
                end
            end
        end else if (addr[15:13] == REGION_RAM_WINDOW) begin
            n_out_data.access_kind = i_in_data.mode ? KIND_RAM_WRITE : KIND_RAM_READ;
            if (!r_ram_enable) begin
                n_out_data.error_code = ERR_RAM_OFF;
            end else if ({3'd0, ram_off} >= r_ram_bytes) begin
                n_out_data.error_code = ERR_RAM_RANGE;
            end else begin
                // banked RAM in RAM mode: upper bits pick the 8 KiB bank
                if (r_ram_is_banked && r_banking_mode) begin
                    n_out_data.physical_address = {6'd0, r_upper_bits, ram_off};
                end else begin
                    n_out_data.physical_address = {8'd0, ram_off};
                end
                if (i_in_data.mode) begin
                    n_out_data.ram_write_byte = i_in_data.write_byte;
                end
            end
        end else if (addr[15]) begin
            n_out_data.access_kind = KIND_IGNORED;
            n_out_data.error_code  = ERR_UNMAPPED;
        end else if (i_in_data.mode) begin
            n_out_data.access_kind = KIND_CONTROL;
            unique case (addr[14:13])
                CTRL_RAM_ENABLE:
                    n_ram_enable = (i_in_data.write_byte[3:0] == RAM_ENABLE_KEY);
                CTRL_LOW_BANK:
                    n_low_bank = (low_bank_wr == 5'd0) ? 5'd1 : low_bank_wr;
                CTRL_UPPER_BITS:
                    n_upper_bits = i_in_data.write_byte[1:0];
                CTRL_BANK_MODE:
                    n_banking_mode = i_in_data.write_byte[0];
                default: ;
            endcase
        end else begin
            n_out_data.access_kind = KIND_ROM_READ;
            // fixed bank 0 below 0x4000, switchable bank above
            if (addr[14]) begin
                n_out_data.physical_address = {rom_bank, addr[13:0]};
            end else begin
                n_out_data.physical_address = {7'd0, addr[13:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_enable   <= 1'b0;
            r_low_bank     <= 5'd1;
            r_upper_bits   <= 2'd0;
            r_banking_mode <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_ram_enable   <= n_ram_enable;
                r_low_bank     <= n_low_bank;
                r_upper_bits   <= n_upper_bits;
                r_banking_mode <= n_banking_mode;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    a_low_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_bank != 5'd0)
        else $error("low bank register holds zero");

    a_error_clears_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data.error_code != ERR_NONE)
        |-> (r_out_data.physical_address == 21'd0) && (r_out_data.ram_write_byte == 8'd0))
        else $error("errored transaction carries an address or data");

    a_wbyte_only_ram_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data.ram_write_byte != 8'd0)
        |-> (r_out_data.access_kind == KIND_RAM_WRITE))
        else $error("write data on a transaction that is not a RAM write");

    a_control_only_mbc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data.access_kind == KIND_CONTROL)
        |-> r_controller_kind && (r_out_data.physical_address == 21'd0))
        else $error("control write reported outside MBC1 mode");

    a_bank_state_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(r_low_bank) && $stable(r_upper_bits)
                     && $stable(r_ram_enable) && $stable(r_banking_mode))
        else $error("bank state changed without an accepted transaction");

endmodule

@@ bench/cbc_translation_monitor.sv @@
`timescale 1ns / 1ps
// Monitor for the cartridge bank controller bench: follows register writes and
// accepted bus accesses, predicts each translated access and compares results
// in order. Depends on cbc_pkg.
module cbc_translation_monitor
    import cbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // register copies
    logic        mbc1_on;
    logic [15:0] ram_bytes;
    logic        ram_banked;
    logic [22:0] rom_bytes;

    // bank state
    logic        ram_enable;
    logic [4:0]  low_bank;
    logic [1:0]  upper_bits;
    logic        ram_mode;

    t_out_item   translations_due[$];
    int          fail_total = 0;
    int          checked_total = 0;

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: mismatch in %s of result %0d: got %0h, want %0h",
                 $realtime, field, checked_total, got, want);
        fail_total++;
    endtask

    function automatic t_out_item translate_access(input t_in_item acc);
        t_out_item   res;
        logic [15:0] a;
        logic [12:0] off;
        logic [6:0]  rom_bank;
        res = '0;
        a = acc.bus_address;

        if (!mbc1_on) begin
            if (acc.mode) begin
                res.access_kind = KIND_IGNORED;
            end else begin
                res.access_kind = KIND_ROM_READ;
                if ({7'd0, a} >= rom_bytes) begin
                    res.error_code = ERR_ROM_RANGE;
                end else begin
                    res.physical_address = {5'd0, a};
                end
            end
            return res;
        end

        if (a[15:13] == REGION_RAM_WINDOW) begin
            res.access_kind = acc.mode ? KIND_RAM_WRITE : KIND_RAM_READ;
            off = a[12:0];
            // the enable check wins over the size check
            if (!ram_enable) begin
                res.error_code = ERR_RAM_OFF;
            end else if ({3'd0, off} >= ram_bytes) begin
                res.error_code = ERR_RAM_RANGE;
            end else begin
                res.physical_address = {6'd0, (ram_banked && ram_mode) ? upper_bits : 2'd0, off};
                if (acc.mode) begin
                    res.ram_write_byte = acc.write_byte;
                end
            end
            return res;
        end

        if (a[15]) begin
            res.access_kind = KIND_IGNORED;
            res.error_code = ERR_UNMAPPED;
            return res;
        end

        if (acc.mode) begin
            case (a[14:13])
                CTRL_RAM_ENABLE: ram_enable = (acc.write_byte[3:0] == RAM_ENABLE_KEY);
                CTRL_LOW_BANK: begin
                    low_bank = (acc.write_byte[4:0] == 5'd0) ? 5'd1 : acc.write_byte[4:0];
                end
                CTRL_UPPER_BITS: upper_bits = acc.write_byte[1:0];
                CTRL_BANK_MODE: ram_mode = acc.write_byte[0];
            endcase
            res.access_kind = KIND_CONTROL;
        end else if (!a[14]) begin
            res.access_kind = KIND_ROM_READ;
            res.physical_address = {5'd0, a};
        end else begin
            res.access_kind = KIND_ROM_READ;
            rom_bank = ram_mode ? {2'd0, low_bank} : {upper_bits, low_bank};
            res.physical_address = {rom_bank, a[13:0]};
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            mbc1_on = 1'b1;
            ram_bytes = '0;
            ram_banked = 1'b0;
            rom_bytes = ROM_BYTES_RESET;
            ram_enable = 1'b0;
            low_bank = 5'd1;
            upper_bits = 2'd0;
            ram_mode = 1'b0;
            translations_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                translations_due = {translations_due, translate_access(i_in_data)};
            end
            if (i_out_valid && !i_out_stall) begin
                checked_total++;
                if (translations_due.size() == 0) begin
                    report_mismatch("transaction with nothing pending",
                                    i_out_data.physical_address, 0);
                end else begin
                    want = translations_due.pop_front();
                    if (i_out_data.access_kind !== want.access_kind) begin
                        report_mismatch("access_kind", i_out_data.access_kind, want.access_kind);
                    end
                    if (i_out_data.error_code !== want.error_code) begin
                        report_mismatch("error_code", i_out_data.error_code, want.error_code);
                    end
                    if (i_out_data.physical_address !== want.physical_address) begin
                        report_mismatch("physical_address", i_out_data.physical_address,
                                        want.physical_address);
                    end
                    if (i_out_data.ram_write_byte !== want.ram_write_byte) begin
                        report_mismatch("ram_write_byte", i_out_data.ram_write_byte,
                                        want.ram_write_byte);
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_CONTROLLER_KIND: mbc1_on = i_pwdata[0];
                    REG_RAM_BYTES: ram_bytes = i_pwdata[15:0];
                    REG_RAM_IS_BANKED: ram_banked = i_pwdata[0];
                    REG_ROM_BYTES: rom_bytes = i_pwdata[22:0];
                endcase
            end
        end
        o_fail_count <= fail_total;
        o_pending <= translations_due.size();
        o_checked <= checked_total;
    end

endmodule

@@ bench/cartridge_bank_controller_test.sv @@
`timescale 1ns / 1ps
// Top of the cartridge bank controller bench: clock, reset, register setup and
// bus access stimulus with random idling; checking sits in cbc_translation_monitor.
// Depends on cbc_pkg, cartridge_bank_controller and cbc_translation_monitor.
module cartridge_bank_controller_test;
    import cbc_pkg::*;

    localparam int   QUIET_LIMIT     = 5000;
    localparam int   ITEMS_PER_PHASE = 100;
    localparam int   DRAIN_CYCLES    = 4;
    localparam logic ACC_READ        = 1'b0;
    localparam logic ACC_WRITE       = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int sent = 0;
    int settings = 0;
    int quiet_cycles = 0;
    bit steady = 1'b0;

    // mirror of the current register setting, used to shape stimulus
    bit cur_mbc1 = 1'b1;
    int cur_ram_bytes = 0;

    cartridge_bank_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    cbc_translation_monitor monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        out_stall = !steady && ($urandom_range(99) < 38);
    end

    // end the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d results pending",
                     quiet_cycles, pending);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item make_access(input logic m, input logic [15:0] a,
                                             input logic [7:0] d);
        t_in_item acc;
        acc.mode = m;
        acc.bus_address = a;
        acc.write_byte = d;
        return acc;
    endfunction

    function automatic t_in_item random_access();
        t_in_item acc;
        int       pick;
        int       span;
        acc.mode = 1'($urandom_range(1));
        acc.bus_address = 16'($urandom);
        acc.write_byte = 8'($urandom);
        if (!cur_mbc1) begin
            return acc;
        end
        pick = $urandom_range(99);
        if (pick < 30) begin
            acc.mode = ACC_WRITE;
            acc.bus_address[15] = 1'b0;
            if (acc.bus_address[14:13] == CTRL_RAM_ENABLE && $urandom_range(1)) begin
                acc.write_byte[3:0] = RAM_ENABLE_KEY;
            end
        end else if (pick < 55) begin
            acc.mode = ACC_READ;
            acc.bus_address[15] = 1'b0;
        end else if (pick < 85) begin
            acc.bus_address[15:13] = REGION_RAM_WINDOW;
            // keep half of the window accesses inside the RAM
            if (cur_ram_bytes != 0 && $urandom_range(1)) begin
                span = (cur_ram_bytes > 8192) ? 8192 : cur_ram_bytes;
                acc.bus_address[12:0] = 13'($urandom_range(span - 1));
            end
        end
        return acc;
    endfunction

    task automatic send_access(input t_in_item acc);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 38) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = acc;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // drop valid and wait until every result has come back
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input bit mbc1, input int ram_bytes, input bit banked,
                             input int rom_bytes);
        settle();
        write_register(REG_CONTROLLER_KIND, 32'(mbc1));
        write_register(REG_RAM_BYTES, ram_bytes);
        write_register(REG_RAM_IS_BANKED, 32'(banked));
        write_register(REG_ROM_BYTES, rom_bytes);
        cur_mbc1 = mbc1;
        cur_ram_bytes = ram_bytes;
        settings++;
    endtask

    task automatic random_phase(input int count);
        repeat (count) send_access(random_access());
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting: MBC1, no RAM
        send_access(make_access(ACC_READ, 16'hA000, 8'h00));   // RAM still disabled
        send_access(make_access(ACC_WRITE, 16'hBFFF, 8'h55));
        send_access(make_access(ACC_WRITE, 16'h0000, 8'h0A));
        send_access(make_access(ACC_READ, 16'hA000, 8'h00));   // enabled but zero size
        send_access(make_access(ACC_READ, 16'h0000, 8'h00));
        send_access(make_access(ACC_READ, 16'h3FFF, 8'h00));
        send_access(make_access(ACC_READ, 16'h4000, 8'h00));
        send_access(make_access(ACC_WRITE, 16'h2000, 8'h00));  // bank zero maps to one
        send_access(make_access(ACC_READ, 16'h7FFF, 8'h00));
        send_access(make_access(ACC_WRITE, 16'h3FFF, 8'hFF));
        send_access(make_access(ACC_WRITE, 16'h4000, 8'hFF));
        send_access(make_access(ACC_READ, 16'h7FFF, 8'h00));   // highest ROM bank
        send_access(make_access(ACC_WRITE, 16'h7FFF, 8'h01));
        send_access(make_access(ACC_READ, 16'h4000, 8'h00));   // upper bits dropped
        send_access(make_access(ACC_WRITE, 16'h8000, 8'hFF));
        send_access(make_access(ACC_READ, 16'hC000, 8'h00));
        send_access(make_access(ACC_READ, 16'hFFFF, 8'h00));
        send_access(make_access(ACC_WRITE, 16'h1FFF, 8'h0B));

        configure(1'b1, 32768, 1'b1, 4194304);
        send_access(make_access(ACC_WRITE, 16'h0000, 8'hFA));
        send_access(make_access(ACC_WRITE, 16'hA000, 8'hFF));  // banked RAM, RAM mode
        send_access(make_access(ACC_READ, 16'hBFFF, 8'h00));
        send_access(make_access(ACC_WRITE, 16'h6000, 8'hFE));
        send_access(make_access(ACC_READ, 16'hBFFF, 8'h00));

        configure(1'b0, 0, 1'b0, 32768);
        send_access(make_access(ACC_READ, 16'h7FFF, 8'h00));
        send_access(make_access(ACC_READ, 16'h8000, 8'h00));   // past the ROM end
        send_access(make_access(ACC_WRITE, 16'h1234, 8'hAA));

        configure(1'b1, 8192, 1'b0, 32768);
        random_phase(ITEMS_PER_PHASE);
        configure(1'b1, 32768, 1'b1, 4194304);
        random_phase(ITEMS_PER_PHASE);
        configure(1'b1, $urandom_range(1, 32768), 1'b1, $urandom_range(32768, 4194304));
        steady = 1'b1;
        random_phase(ITEMS_PER_PHASE);
        steady = 1'b0;
        configure(1'b0, $urandom_range(32768), 1'($urandom_range(1)), 32768);
        random_phase(ITEMS_PER_PHASE);
        configure(1'b0, 0, 1'b0, $urandom_range(32768, 65535));
        random_phase(ITEMS_PER_PHASE);
        configure(1'b1, 0, 1'b0, int'(ROM_BYTES_RESET));
        random_phase(ITEMS_PER_PHASE);

        settle();
        $display("sent %0d bus accesses under %0d register settings, %0d results compared",
                 sent, settings + 1, checked);
        $display("covered plain ROM and MBC1 decode, bank switching, RAM window errors");
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/cbc_pkg.sv
src/cartridge_bank_controller.sv
bench/cbc_translation_monitor.sv
bench/cartridge_bank_controller_test.sv
